FILE: src/bat_pkg.sv
// Shared types for the breakpoint address table: command and status codes,
// controller states and the control/status groups between controller and datapath.
// No dependencies.
package bat_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_FULL    = 2'd1,
        STS_PRESENT = 2'd2,
        STS_ABSENT  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COMP,
        S_DECIDE,
        S_SH_READ,
        S_SH_WRITE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    idx_inc;
        logic    set_found;
        logic    wr_append;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    out_load;
        status_t out_status;
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        cmd_t in_cmd;
        cmd_t cmd;
        logic out_busy;
        logic match;
        logic last;
        logic full;
        logic count_zero;
        logic found;
    } stat_t;

endpackage

FILE: src/breakpoint_address_table_top.sv
// Breakpoint address table, top level. One item at a time.
// Clear, or any command on an empty table, goes straight to the result; other commands scan
// the entries in order, reading each from the RAM (registered read) and then comparing it, and
// the scan stops at the first match. After a remove, later entries move down before the result.
// The next item is accepted once the result has been taken.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module breakpoint_address_table_top #(
    parameter int MAX_BREAKPOINTS = 16,
    parameter int ADDR_BITS       = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] address, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [2] hit, [7:3] entry_count
);

    bat_pkg::ctrl_t ctrl;
    bat_pkg::stat_t stat;
    logic [1:0]     out_status;
    logic           out_hit;
    logic [4:0]     out_count;

    bat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    bat_dp #(
        .MAX_BREAKPOINTS(MAX_BREAKPOINTS),
        .ADDR_BITS      (ADDR_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (s_tuser),
        .in_addr   (s_tdata[11:0]),
        .ctrl      (ctrl),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_status(out_status),
        .out_hit   (out_hit),
        .out_count (out_count)
    );

    assign m_tdata = {out_count, out_hit, out_status};

endmodule

FILE: src/bat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bat_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/bat_ctrl.sv
// Controller state machine of the breakpoint address table: sequences the
// entry scan, the add/remove decision and the shift-down after a remove.
// Depends on bat_pkg.
module bat_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bat_pkg::stat_t stat,
    output bat_pkg::ctrl_t ctrl
);

    bat_pkg::state_t state_reg;
    bat_pkg::state_t state_next;
    logic            accept;

    assign s_tready = (state_reg == bat_pkg::S_IDLE) && !stat.out_busy;
    assign accept   = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bat_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bat_pkg::S_IDLE: begin
                if (accept) begin
                    if (stat.in_cmd == bat_pkg::CMD_CLEAR || stat.count_zero) begin
                        state_next = bat_pkg::S_DECIDE;
                    end else begin
                        state_next = bat_pkg::S_READ;
                    end
                end
            end
            bat_pkg::S_READ: begin
                state_next = bat_pkg::S_COMP;
            end
            bat_pkg::S_COMP: begin
                if (stat.match || stat.last) begin
                    state_next = bat_pkg::S_DECIDE;
                end else begin
                    state_next = bat_pkg::S_READ;
                end
            end
            bat_pkg::S_DECIDE: begin
                if (stat.cmd == bat_pkg::CMD_REMOVE && stat.found && !stat.last) begin
                    state_next = bat_pkg::S_SH_READ;
                end else begin
                    state_next = bat_pkg::S_IDLE;
                end
            end
            bat_pkg::S_SH_READ: begin
                state_next = bat_pkg::S_SH_WRITE;
            end
            bat_pkg::S_SH_WRITE: begin
                if (stat.last) begin
                    state_next = bat_pkg::S_IDLE;
                end else begin
                    state_next = bat_pkg::S_SH_READ;
                end
            end
            default: begin
                state_next = bat_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        ctrl            = '0;
        ctrl.out_status = bat_pkg::STS_DONE;
        unique case (state_reg)
            bat_pkg::S_IDLE: begin
                ctrl.load_in = accept;
            end
            bat_pkg::S_READ: begin
                // read address is the scan index; data shows up in S_COMP
            end
            bat_pkg::S_COMP: begin
                if (stat.match) begin
                    ctrl.set_found = 1'b1;
                end else if (!stat.last) begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            bat_pkg::S_DECIDE: begin
                ctrl.out_load = 1'b1;
                unique case (stat.cmd)
                    bat_pkg::CMD_ADD: begin
                        if (stat.full) begin
                            ctrl.out_status = bat_pkg::STS_FULL;
                        end else if (stat.found) begin
                            ctrl.out_status = bat_pkg::STS_PRESENT;
                        end else begin
                            ctrl.wr_append = 1'b1;
                            ctrl.cnt_inc   = 1'b1;
                        end
                    end
                    bat_pkg::CMD_REMOVE: begin
                        if (!stat.found) begin
                            ctrl.out_status = bat_pkg::STS_ABSENT;
                        end else if (stat.last) begin
                            ctrl.cnt_dec = 1'b1;
                        end else begin
                            // later entries move down first; result comes after
                            ctrl.out_load = 1'b0;
                            ctrl.idx_inc  = 1'b1;
                        end
                    end
                    bat_pkg::CMD_CHECK: begin
                    end
                    bat_pkg::CMD_CLEAR: begin
                        ctrl.cnt_clr = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            bat_pkg::S_SH_READ: begin
            end
            bat_pkg::S_SH_WRITE: begin
                ctrl.wr_shift = 1'b1;
                if (stat.last) begin
                    ctrl.cnt_dec  = 1'b1;
                    ctrl.out_load = 1'b1;
                end else begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/bat_dp.sv
// Datapath of the breakpoint address table: entry RAM, scan index, entry
// count, input latch and result register.
// Depends on bat_pkg and bat_ram.
module bat_dp #(
    parameter int MAX_BREAKPOINTS = 16,
    parameter int ADDR_BITS       = 12
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      in_cmd,
    input  logic [11:0]     in_addr,
    input  bat_pkg::ctrl_t  ctrl,
    output bat_pkg::stat_t  stat,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [1:0]      out_status,
    output logic            out_hit,
    output logic [4:0]      out_count
);

    localparam int IDX_W = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam int CNT_W = $clog2(MAX_BREAKPOINTS + 1);

    bat_pkg::cmd_t      cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               found_reg;
    logic               ovalid_reg;
    bat_pkg::status_t   ostatus_reg;
    logic               ohit_reg;
    logic [4:0]         ocount_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ADDR_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0] ram_rdata;
    logic [CNT_W-1:0]     idx_plus1;
    logic [CNT_W-1:0]     idx_minus1;

    assign idx_plus1  = idx_reg + 1'b1;
    assign idx_minus1 = idx_reg - 1'b1;

    // Entry storage
    assign ram_we    = ctrl.wr_append || ctrl.wr_shift;
    assign ram_waddr = ctrl.wr_append ? count_reg[IDX_W-1:0] : idx_minus1[IDX_W-1:0];
    assign ram_wdata = ctrl.wr_append ? addr_reg : ram_rdata;

    bat_ram #(
        .WIDTH(ADDR_BITS),
        .DEPTH(MAX_BREAKPOINTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    // Scan index and entry count
    always_comb begin
        idx_next = idx_reg;
        if (ctrl.load_in) begin
            idx_next = '0;
        end else if (ctrl.idx_inc) begin
            idx_next = idx_plus1;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.cnt_clr) begin
            count_next = '0;
        end else if (ctrl.cnt_inc) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.cnt_dec) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (ctrl.out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Item latch, scan state and result payload
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (ctrl.load_in) begin
            cmd_reg   <= bat_pkg::cmd_t'(in_cmd);
            addr_reg  <= ADDR_BITS'(in_addr);
            found_reg <= 1'b0;
        end else if (ctrl.set_found) begin
            found_reg <= 1'b1;
        end
        if (ctrl.out_load) begin
            ostatus_reg <= ctrl.out_status;
            ohit_reg    <= found_reg;
            ocount_reg  <= 5'(count_next);
        end
    end

    // Status toward the controller
    always_comb begin
        stat            = '0;
        stat.in_cmd     = bat_pkg::cmd_t'(in_cmd);
        stat.cmd        = cmd_reg;
        stat.out_busy   = ovalid_reg;
        stat.match      = (ram_rdata == addr_reg);
        stat.last       = (idx_plus1 == count_reg);
        stat.full       = (count_reg >= CNT_W'(MAX_BREAKPOINTS));
        stat.count_zero = (count_reg == '0);
        stat.found      = found_reg;
    end

    assign m_tvalid   = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_hit    = ohit_reg;
    assign out_count  = ocount_reg;

endmodule
